>>> rtl/bas_pkg.sv
`timescale 1ns / 1ps

package bas_pkg;

    // Fixed field widths
    localparam int DATA_W    = 8;
    localparam int PATTERN_W = 16;
    localparam int OUT_POS_W = 32;
    localparam int OFFSET_W  = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN       = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_BASE = CFG_INDEX_W'(1);

    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 16'h787E;

    localparam int POSITION_BITS_DEFAULT = 32;

    // Checks per byte: eight window offsets plus the end-of-stream check
    localparam int NUM_CHECKS = 9;
    localparam int EOS_CHECK  = 8;

    // Hits of one byte, waiting to be sent out one at a time
    typedef struct packed {
        logic [NUM_CHECKS-1:0] mask;    // bit j: window offset j, top bit: final check
        logic [OUT_POS_W-1:0]  pos_win; // position of window hits
        logic [OUT_POS_W-1:0]  pos_eos; // position of the final-pair hit
    } hit_t;

endpackage

>>> rtl/bas_match.sv
`timescale 1ns / 1ps

module bas_match #(
    parameter int POSITION_BITS = bas_pkg::POSITION_BITS_DEFAULT
) (
    input  logic [bas_pkg::DATA_W-1:0]     data_byte,
    input  logic                           end_of_stream,
    input  logic [bas_pkg::DATA_W-1:0]     older_byte,
    input  logic [bas_pkg::DATA_W-1:0]     newer_byte,
    input  logic [((POSITION_BITS < 32) ? POSITION_BITS : 32)-1:0] byte_count,
    input  logic [bas_pkg::PATTERN_W-1:0]  pattern,
    input  logic [bas_pkg::OUT_POS_W-1:0]  position_base,
    output bas_pkg::hit_t                  hit
);

    localparam int CW = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam int LW = (POSITION_BITS < 33) ? POSITION_BITS : 33;
    // Largest reportable position, seen in the 33-bit sum
    localparam logic [32:0] POS_LIMIT = {33{1'b1}} >> (33 - LW);

    // base + index, clamped to the position range, low 32 bits kept
    function automatic logic [31:0] sat_pos(input logic [31:0] base,
                                            input logic [CW-1:0] idx);
        logic [32:0] sum;
        sum = {1'b0, base} + 33'(idx);
        if (sum > POS_LIMIT) begin
            return POS_LIMIT[31:0];
        end else begin
            return sum[31:0];
        end
    endfunction

    logic [3*bas_pkg::DATA_W-1:0] window;
    logic                         have_two;
    logic                         have_one;

    assign window   = {older_byte, newer_byte, data_byte};
    assign have_two = (byte_count[CW-1:1] != '0);
    assign have_one = (byte_count != '0);

    // Eight fixed comparators plus the final-pair check
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            hit.mask[j] = have_two && (window[23-j -: 16] == pattern);
        end
        hit.mask[bas_pkg::EOS_CHECK] = end_of_stream && have_one &&
                                       ({newer_byte, data_byte} == pattern);
        hit.pos_win = sat_pos(position_base, CW'(byte_count - CW'(2)));
        hit.pos_eos = sat_pos(position_base, CW'(byte_count - CW'(1)));
    end

endmodule

>>> rtl/bas_emit.sv
`timescale 1ns / 1ps

module bas_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_load,
    input  bas_pkg::hit_t                 in_hit,
    output logic                          in_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bas_pkg::OUT_POS_W-1:0] m_match_position,
    output logic [bas_pkg::OFFSET_W-1:0]  m_bit_offset,
    output logic                          m_last_result
);

    bas_pkg::hit_t hit_reg, hit_next;

    logic                          m_valid_reg, m_valid_next;
    logic [bas_pkg::OUT_POS_W-1:0] pos_reg, pos_next;
    logic [bas_pkg::OFFSET_W-1:0]  off_reg, off_next;
    logic                          last_reg, last_next;

    logic [bas_pkg::NUM_CHECKS-1:0] pick;
    logic [bas_pkg::NUM_CHECKS-1:0] rest;
    logic [bas_pkg::OFFSET_W-1:0]   pick_off;
    logic                           drain;

    // Lowest pending hit goes first
    always_comb begin
        pick     = hit_reg.mask & (~hit_reg.mask + 1'b1);
        rest     = hit_reg.mask & ~pick;
        pick_off = '0;
        for (int j = 0; j < 8; j++) begin
            if (pick[j]) begin
                pick_off = pick_off | bas_pkg::OFFSET_W'(j);
            end
        end
        drain    = (hit_reg.mask != '0) && (!m_valid_reg || m_ready);
        in_ready = (hit_reg.mask == '0) || (drain && rest == '0);
    end

    // Next pending hits and output register
    always_comb begin
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        pos_next     = pos_reg;
        off_next     = off_reg;
        last_next    = last_reg;
        if (drain) begin
            hit_next.mask = rest;
            m_valid_next  = 1'b1;
            pos_next      = pick[bas_pkg::EOS_CHECK] ? hit_reg.pos_eos : hit_reg.pos_win;
            off_next      = pick_off;
            last_next     = (rest == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (in_load) begin
            hit_next = in_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg.mask <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            hit_reg.mask <= hit_next.mask;
            m_valid_reg  <= m_valid_next;
        end
        hit_reg.pos_win <= hit_next.pos_win;
        hit_reg.pos_eos <= hit_next.pos_eos;
        pos_reg         <= pos_next;
        off_reg         <= off_next;
        last_reg        <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_match_position = pos_reg;
    assign m_bit_offset     = off_reg;
    assign m_last_result    = last_reg;

endmodule

>>> rtl/bit_aligned_pattern_search_top.sv
// Finds a 16-bit pattern at any bit alignment in a byte stream. Each byte taken on
// the s_ channel is checked at offsets 0..7 against the two bytes before it (once
// two earlier bytes exist), and on an end-of-stream byte the final two bytes are
// checked at offset 0 too. Every hit comes out on the m_ channel as one item with
// its byte position (position_base plus index, clamped to POSITION_BITS) and bit
// offset, window hits by ascending offset, then the final pair, last_result on the last.
// Hits leave one per cycle through a single output register while m_ready is
// held, so bytes with zero or one hit stream at one per clock; hits wait in a
// pending register first. The user writes registers through cfg_* (index 0
// pattern, 1 position_base) only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module bit_aligned_pattern_search_top #(
    parameter int POSITION_BITS = bas_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bas_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bas_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bas_pkg::DATA_W-1:0]       s_data_byte,
    input  logic                             s_end_of_stream,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bas_pkg::OUT_POS_W-1:0]    m_match_position,
    output logic [bas_pkg::OFFSET_W-1:0]     m_bit_offset,
    output logic                             m_last_result
);

    localparam int CW = (POSITION_BITS < 32) ? POSITION_BITS : 32;

    logic [bas_pkg::PATTERN_W-1:0] pattern_reg;
    logic [bas_pkg::OUT_POS_W-1:0] base_reg;
    logic [bas_pkg::DATA_W-1:0]    older_reg, older_next;
    logic [bas_pkg::DATA_W-1:0]    newer_reg, newer_next;
    logic [CW-1:0]                 count_reg, count_next;

    bas_pkg::hit_t hit;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= bas_pkg::PATTERN_RESET;
            base_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bas_pkg::REG_PATTERN:       pattern_reg <= cfg_data[bas_pkg::PATTERN_W-1:0];
                bas_pkg::REG_POSITION_BASE: base_reg    <= cfg_data[bas_pkg::OUT_POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Byte history and saturating byte count; end of stream starts over
    always_comb begin
        older_next = older_reg;
        newer_next = newer_reg;
        count_next = count_reg;
        if (accept) begin
            if (s_end_of_stream) begin
                older_next = '0;
                newer_next = '0;
                count_next = '0;
            end else begin
                older_next = newer_reg;
                newer_next = s_data_byte;
                if (!(&count_reg)) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg <= '0;
            newer_reg <= '0;
            count_reg <= '0;
        end else begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
        end
    end

    bas_match #(
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .data_byte     (s_data_byte),
        .end_of_stream (s_end_of_stream),
        .older_byte    (older_reg),
        .newer_byte    (newer_reg),
        .byte_count    (count_reg),
        .pattern       (pattern_reg),
        .position_base (base_reg),
        .hit           (hit)
    );

    bas_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_load          (accept),
        .in_hit           (hit),
        .in_ready         (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_position (m_match_position),
        .m_bit_offset     (m_bit_offset),
        .m_last_result    (m_last_result)
    );

endmodule

>>> bench/bit_aligned_pattern_search_top_test.sv
`timescale 1ns / 1ps

module bit_aligned_pattern_search_top_test;
    import bas_pkg::*;

    localparam int unsigned RANDOM_BYTES = 180;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    // Indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE     = REG_POSITION_BASE + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_INDEX = '1;

    typedef enum logic [1:0] {ROW_BYTE, ROW_WRITE} row_kind_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} row_check_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [DATA_W-1:0]      data_byte;
        logic                   eos;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        row_check_e             check;
        logic [OUT_POS_W-1:0]   pos;
        logic [OFFSET_W-1:0]    off;
    } plan_row_t;

    typedef struct packed {
        logic [OUT_POS_W-1:0] pos;
        logic [OFFSET_W-1:0]  off;
        logic                 last;
    } hit_rec_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [DATA_W-1:0]      s_data_byte = '0;
    logic                   s_end_of_stream = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_POS_W-1:0]   m_match_position;
    logic [OFFSET_W-1:0]    m_bit_offset;
    logic                   m_last_result;

    bit_aligned_pattern_search_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_position (m_match_position),
        .m_bit_offset     (m_bit_offset),
        .m_last_result    (m_last_result)
    );

    // Search state mirrored on the bench side
    logic [PATTERN_W-1:0] search_word = PATTERN_RESET;
    logic [OUT_POS_W-1:0] base_reg = '0;
    logic [DATA_W-1:0]    prev2 = '0;
    logic [DATA_W-1:0]    prev1 = '0;
    logic [OUT_POS_W-1:0] seen_bytes = '0;

    hit_rec_t    byte_hits[$];
    hit_rec_t    pending_hits[$];
    hit_rec_t    want_hit;
    int unsigned fails = 0;
    int unsigned cycles = 0;
    int unsigned sink_gap = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;
    bit          src_high = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // base + index, clamped at the top of the position range
    function automatic logic [OUT_POS_W-1:0] clamp_pos(input logic [OUT_POS_W-1:0] idx);
        logic [OUT_POS_W:0] sum;
        sum = {1'b0, base_reg} + {1'b0, idx};
        return sum[OUT_POS_W] ? '1 : sum[OUT_POS_W-1:0];
    endfunction

    // Hits caused by one byte, in output order; advances the stream state
    function automatic void scan_byte(input logic [DATA_W-1:0] b, input logic eos);
        logic [23:0] window;
        hit_rec_t    rec;
        byte_hits.delete();
        window = {prev2, prev1, b};
        if (seen_bytes >= 2) begin
            for (int j = 0; j < 8; j++) begin
                if (window[23-j -: 16] == search_word)
                    byte_hits.push_back({clamp_pos(seen_bytes - 2), OFFSET_W'(j), 1'b0});
            end
        end
        if (eos && seen_bytes >= 1 && {prev1, b} == search_word)
            byte_hits.push_back({clamp_pos(seen_bytes - 1), OFFSET_W'(0), 1'b0});
        if (byte_hits.size() != 0) begin
            rec = byte_hits.pop_back();
            rec.last = 1'b1;
            byte_hits.push_back(rec);
        end
        if (eos) begin
            prev2 = '0;
            prev1 = '0;
            seen_bytes = '0;
        end else begin
            prev2 = prev1;
            prev1 = b;
            if (seen_bytes != '1) seen_bytes++;
        end
    endfunction

    function automatic plan_row_t byte_row(input logic [DATA_W-1:0] b, input logic eos,
                                           input row_check_e check,
                                           input logic [OUT_POS_W-1:0] pos,
                                           input logic [OFFSET_W-1:0] off);
        plan_row_t r;
        r = '0;
        r.kind = ROW_BYTE;
        r.data_byte = b;
        r.eos = eos;
        r.check = check;
        r.pos = pos;
        r.off = off;
        return r;
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_index = idx;
        r.reg_value = val;
        r.check = CHK_MODEL;
        return r;
    endfunction

    task automatic release_input();
        if (src_high) begin
            s_valid <= 1'b0;
            src_high = 1'b0;
        end
    endtask

    task automatic idle_input(input int unsigned n);
        if (n != 0) begin
            release_input();
            repeat (n) @(posedge aclk);
        end
    endtask

    // Present one byte, hold it until taken, then queue what it should produce
    task automatic feed_byte(input logic [DATA_W-1:0] b, input logic eos,
                             input row_check_e check,
                             input logic [OUT_POS_W-1:0] pos,
                             input logic [OFFSET_W-1:0] off);
        s_valid <= 1'b1;
        src_high = 1'b1;
        s_data_byte <= b;
        s_end_of_stream <= eos;
        do @(posedge aclk); while (!s_ready);
        scan_byte(b, eos);
        case (check)
            CHK_MODEL: begin
                foreach (byte_hits[i]) pending_hits.push_back(byte_hits[i]);
            end
            CHK_HIT: begin
                pending_hits.push_back({pos, off, 1'b1});
            end
            default: ;
        endcase
        idle_input(src_calm ? 0 : pick_gap());
    endtask

    // Wait until every hit is out and the pipeline has emptied
    task automatic drain_results();
        release_input();
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PATTERN)
            search_word = val[PATTERN_W-1:0];
        else if (idx == REG_POSITION_BASE)
            base_reg = val;
    endtask

    // Result side: random back-pressure
    always @(posedge aclk) begin
        if (sink_gap != 0) begin
            sink_gap = sink_gap - 1;
            m_ready <= 1'b0;
        end else if (sink_calm) begin
            m_ready <= 1'b1;
        end else begin
            sink_gap = pick_gap();
            m_ready <= (sink_gap == 0);
        end
    end

    // Compare each hit taken against the oldest one queued
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected item: match_position %h bit_offset %0d last_result %0d",
                       m_match_position, m_bit_offset, m_last_result);
                fails++;
            end else begin
                want_hit = pending_hits.pop_front();
                if (m_match_position !== want_hit.pos) begin
                    $error("match_position: expected %h, got %h",
                           want_hit.pos, m_match_position);
                    fails++;
                end
                if (m_bit_offset !== want_hit.off) begin
                    $error("bit_offset: expected %0d, got %0d", want_hit.off, m_bit_offset);
                    fails++;
                end
                if (m_last_result !== want_hit.last) begin
                    $error("last_result: expected %0d, got %0d",
                           want_hit.last, m_last_result);
                    fails++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        plan_row_t         plan[$];
        plan_row_t         row;
        logic [DATA_W-1:0] frame[16];
        logic [PATTERN_W-1:0] word;
        logic [CFG_DATA_W-1:0] base_pick;
        logic              stream_ends;
        int unsigned       len, bitpos, spot, phase, phase_bytes, sent, style;

        // Directed table, starting from the reset word 0x787E and base 0
        plan.push_back(byte_row(8'h78, 1'b0, CHK_NONE, '0, '0));
        plan.push_back(byte_row(8'h7E, 1'b0, CHK_NONE, '0, '0)); // too short for a window
        plan.push_back(byte_row(8'h00, 1'b0, CHK_HIT, 32'd0, 3'd0));
        plan.push_back(byte_row(8'hFF, 1'b1, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'h78, 1'b1, CHK_NONE, '0, '0)); // lone end marker
        plan.push_back(byte_row(8'h78, 1'b0, CHK_NONE, '0, '0));
        plan.push_back(byte_row(8'h7E, 1'b1, CHK_HIT, 32'd0, 3'd0)); // final pair only
        // word shifted three bits into the window
        plan.push_back(byte_row(8'h0F, 1'b0, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'h0F, 1'b0, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'hC0, 1'b1, CHK_MODEL, '0, '0));
        // all ones: every offset hits, positions run into saturation
        plan.push_back(write_row(REG_PATTERN, 32'hFFFF_FFFF));
        plan.push_back(write_row(REG_POSITION_BASE, 32'hFFFF_FFFE));
        plan.push_back(byte_row(8'hFF, 1'b0, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'hFF, 1'b0, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'hFF, 1'b0, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'hFF, 1'b1, CHK_MODEL, '0, '0));
        // all zeros with the largest base: nine hits on the last byte
        plan.push_back(write_row(REG_PATTERN, 32'h0000_0000));
        plan.push_back(write_row(REG_POSITION_BASE, 32'hFFFF_FFFF));
        plan.push_back(byte_row(8'h00, 1'b0, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'h00, 1'b0, CHK_MODEL, '0, '0));
        plan.push_back(byte_row(8'h00, 1'b1, CHK_MODEL, '0, '0));
        // writes to unknown indexes leave both registers alone
        plan.push_back(write_row(REG_SPARE, 32'h0000_5555));
        plan.push_back(write_row(REG_TOP_INDEX, 32'hFFFF_FFFF));
        plan.push_back(byte_row(8'h00, 1'b0, CHK_NONE, '0, '0));
        plan.push_back(byte_row(8'h00, 1'b1, CHK_HIT, 32'hFFFF_FFFF, 3'd0));
        // upper half of a pattern write is dropped
        plan.push_back(write_row(REG_PATTERN, 32'hABCD_1234));
        plan.push_back(write_row(REG_POSITION_BASE, 32'h0000_0100));
        plan.push_back(byte_row(8'h12, 1'b0, CHK_NONE, '0, '0));
        plan.push_back(byte_row(8'h34, 1'b1, CHK_HIT, 32'h0000_0100, 3'd0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
                write_reg(row.reg_index, row.reg_value);
            else
                feed_byte(row.data_byte, row.eos, row.check, row.pos, row.off);
        end

        // Random phases, each with its own register setting and idling mode
        sent = 0;
        for (phase = 0; phase < 40 && sent < RANDOM_BYTES; phase++) begin
            case (phase % 6)
                0: begin
                    word = 16'($urandom);
                    base_pick = '0;
                end
                1: begin
                    word = 16'h0000;
                    base_pick = '1;
                end
                2: begin
                    word = 16'hFFFF;
                    base_pick = $urandom;
                end
                3: begin
                    word = 16'($urandom);
                    base_pick = 32'hFFFF_FFF0;
                end
                4: begin
                    word = {2{8'($urandom)}};
                    base_pick = $urandom;
                end
                default: begin
                    word = PATTERN_RESET;
                    base_pick = '0;
                end
            endcase
            write_reg(REG_PATTERN, {16'($urandom), word});
            write_reg(REG_POSITION_BASE, base_pick);
            src_calm = ($urandom_range(3) == 0);
            sink_calm = ($urandom_range(3) == 0);

            phase_bytes = 0;
            while (phase_bytes < 30) begin
                len = ($urandom_range(9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 12);
                // 0..6 word planted, 7 planted then corrupted, 8 noise, 9 noise left open
                style = $urandom_range(9);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(3) == 0) begin
                        case ($urandom_range(3))
                            0: frame[i] = word[15:8];
                            1: frame[i] = word[7:0];
                            2: frame[i] = 8'h00;
                            default: frame[i] = 8'hFF;
                        endcase
                    end else begin
                        frame[i] = 8'($urandom);
                    end
                end
                if (style < 8 && len >= 2) begin
                    bitpos = $urandom_range(8 * len - 16);
                    for (int i = 0; i < 16; i++) begin
                        spot = bitpos + i;
                        frame[spot / 8][7 - (spot % 8)] = word[15 - i];
                    end
                    if (style == 7) begin
                        spot = bitpos + $urandom_range(15);
                        frame[spot / 8][7 - (spot % 8)] = ~frame[spot / 8][7 - (spot % 8)];
                    end
                end
                stream_ends = (style != 9);
                for (int i = 0; i < len; i++)
                    feed_byte(frame[i], stream_ends && (i == len - 1), CHK_MODEL, '0, '0);
                sent += len;
                phase_bytes += len;
            end
        end

        drain_results();
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
